/* hdl/dmm_pkg.sv */
// Package for the dense matrix multiplier: operation codes, field widths,
// register indexes and the control struct passed to the multiply-accumulate unit.
// No dependencies.
package dmm_pkg;

  localparam int OP_W   = 2;
  localparam int POS_W  = 6;
  localparam int VAL_W  = 16;
  localparam int MUL_W  = 2 * VAL_W;
  localparam int PROD_W = 35;
  localparam int DIM_W  = 4;
  localparam int IDX_W  = 3;
  localparam int CNT_W  = 7;

  localparam logic [OP_W-1:0] OP_LOAD_A  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_B  = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

  localparam logic [1:0] REG_ROWS_A    = 2'd0;
  localparam logic [1:0] REG_INNER_DIM = 2'd1;
  localparam logic [1:0] REG_COLS_B    = 2'd2;

  typedef struct packed {
    logic valid;
    logic first;
  } mac_ctl_t;

endpackage

/* hdl/dmm_mac.sv */
// Shared multiply-accumulate unit: one registered 16x16 signed multiplier
// followed by a 35-bit accumulator. Depends on dmm_pkg.
module dmm_mac
  import dmm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  mac_ctl_t                 ctl,
  input  logic signed [VAL_W-1:0]  a,
  input  logic signed [VAL_W-1:0]  b,
  output logic                     busy,
  output logic signed [PROD_W-1:0] acc
);

  mac_ctl_t                ctl_q;
  logic signed [MUL_W-1:0] prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl;
    end
  end

  always_ff @(posedge clk) begin
    prod <= MUL_W'(a) * MUL_W'(b);
  end

  // The first term of a dot product replaces the old sum instead of adding to it.
  always_ff @(posedge clk) begin
    if (ctl_q.valid) begin
      if (ctl_q.first) begin
        acc <= {{(PROD_W-MUL_W){prod[MUL_W-1]}}, prod};
      end else begin
        acc <= acc + {{(PROD_W-MUL_W){prod[MUL_W-1]}}, prod};
      end
    end
  end

  assign busy = ctl_q.valid;

endmodule

/* hdl/dense_matrix_multiply.sv */
// Dense matrix multiply C = A x B in signed Q8.8, results exact Q19.16.
// Load items are taken and the block is ready again at once.
// A compute item walks every element of C: each element runs inner reads
// through the single shared multiply-accumulate unit, then drains the
// pipeline and goes into the output register.
// Reset (synchronous) sets the three shape registers to 8; stores are not cleared.
module dense_matrix_multiply
  import dmm_pkg::*;
#(
  parameter int MAX_DIM = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // position[5:0], value[21:6], zero pad
  input  logic [1:0]  s_tuser,   // operation[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // product[34:0], out_row[37:35], out_col[40:38], zero pad
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [DIM_W-1:0] rows_a, inner_dim, cols_b;
  logic [DIM_W-1:0] m_dim, n_dim, p_dim;
  logic [7:0]       area_a, area_b;

  logic [1:0]       state;
  logic [IDX_W-1:0] i_idx, j_idx, k_idx;
  logic [CNT_W-1:0] row_base, ia, ib;
  logic             k_end, j_end, i_end;

  logic signed [VAL_W-1:0] mem_a [DEPTH];
  logic signed [VAL_W-1:0] mem_b [DEPTH];
  logic signed [VAL_W-1:0] a_q, b_q;
  logic                    rd_issue;
  mac_ctl_t                rd_ctl;
  logic                    mac_busy;
  logic signed [PROD_W-1:0] acc;

  logic [OP_W-1:0]  in_op;
  logic [POS_W-1:0] in_pos;
  logic [VAL_W-1:0] in_val;
  logic             in_fire;
  logic             out_free;

  logic [PROD_W-1:0] out_product;
  logic [IDX_W-1:0]  out_row, out_col;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] raw);
    logic [DIM_W-1:0] v;
    begin
      v = raw;
      if (raw == '0) begin
        v = DIM_W'(1);
      end else if (raw > DIM_W'(MAX_DIM)) begin
        v = DIM_W'(MAX_DIM);
      end
      return v;
    end
  endfunction

  // Configuration registers.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a    <= DIM_W'(8);
      inner_dim <= DIM_W'(8);
      cols_b    <= DIM_W'(8);
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_ROWS_A:    rows_a    <= pwdata[DIM_W-1:0];
        REG_INNER_DIM: inner_dim <= pwdata[DIM_W-1:0];
        REG_COLS_B:    cols_b    <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ROWS_A:    prdata = {28'd0, rows_a};
      REG_INNER_DIM: prdata = {28'd0, inner_dim};
      REG_COLS_B:    prdata = {28'd0, cols_b};
      default:       prdata = '0;
    endcase
  end

  assign m_dim  = clamp_dim(rows_a);
  assign n_dim  = clamp_dim(inner_dim);
  assign p_dim  = clamp_dim(cols_b);
  assign area_a = {4'b0000, m_dim} * {4'b0000, n_dim};
  assign area_b = {4'b0000, n_dim} * {4'b0000, p_dim};

  // Input side.
  assign in_op    = s_tuser;
  assign in_pos   = s_tdata[POS_W-1:0];
  assign in_val   = s_tdata[POS_W+VAL_W-1:POS_W];
  assign s_tready = (state == ST_IDLE);
  assign in_fire  = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (in_fire && in_op == OP_LOAD_A && {2'b00, in_pos} < area_a) begin
      mem_a[in_pos[AW-1:0]] <= in_val;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_op == OP_LOAD_B && {2'b00, in_pos} < area_b) begin
      mem_b[in_pos[AW-1:0]] <= in_val;
    end
  end

  assign rd_issue = (state == ST_RUN);

  always_ff @(posedge clk) begin
    if (rd_issue) begin
      a_q <= mem_a[ia[AW-1:0]];
      b_q <= mem_b[ib[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ctl <= '0;
    end else begin
      rd_ctl.valid <= rd_issue;
      rd_ctl.first <= (k_idx == '0);
    end
  end

  dmm_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctl  (rd_ctl),
    .a    (a_q),
    .b    (b_q),
    .busy (mac_busy),
    .acc  (acc)
  );

  // Sequencer over rows, columns and the inner index.
  assign k_end    = ({1'b0, k_idx} == n_dim - DIM_W'(1));
  assign j_end    = ({1'b0, j_idx} == p_dim - DIM_W'(1));
  assign i_end    = ({1'b0, i_idx} == m_dim - DIM_W'(1));
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_fire && in_op == OP_COMPUTE) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (k_end) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!rd_ctl.valid && !mac_busy) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            state <= (i_end && j_end) ? ST_IDLE : ST_RUN;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        i_idx    <= '0;
        j_idx    <= '0;
        k_idx    <= '0;
        row_base <= '0;
        ia       <= '0;
        ib       <= '0;
      end
      ST_RUN: begin
        if (!k_end) begin
          k_idx <= k_idx + IDX_W'(1);
          ia    <= ia + CNT_W'(1);
          ib    <= ib + {3'b000, p_dim};
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          k_idx <= '0;
          if (j_end) begin
            i_idx    <= i_idx + IDX_W'(1);
            j_idx    <= '0;
            row_base <= row_base + {3'b000, n_dim};
            ia       <= row_base + {3'b000, n_dim};
            ib       <= '0;
          end else begin
            j_idx <= j_idx + IDX_W'(1);
            ia    <= row_base;
            ib    <= {4'b0000, j_idx} + CNT_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // Output register; it holds one finished element while the sequencer moves on.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_EMIT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_free) begin
      out_product <= acc;
      out_row     <= i_idx;
      out_col     <= j_idx;
      m_tlast     <= i_end && j_end;
    end
  end

  assign m_tdata = {7'd0, out_col, out_row, out_product};

endmodule

/* hdl/dmm_checker.sv */
// Port-level checker for the dense matrix multiplier, bound to the top level.
// Depends on dmm_pkg and on dense_matrix_multiply.
module dmm_checker
  import dmm_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic        m_tlast
);

  // A result that is not taken stays on the port unchanged.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  // A compute transaction makes the block busy on the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == OP_COMPUTE |=> !s_tready)
    else $error("input still ready after compute transaction");

  // Loads and unused codes never stall the input.
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser != OP_COMPUTE |=> s_tready)
    else $error("input stalled after a load transaction");

  // While non-final elements are delivered the product is still being walked.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |-> !s_tready)
    else $error("input ready in the middle of a product");

endmodule

bind dense_matrix_multiply dmm_checker u_dmm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

/* sim/tb.sv */
// Testbench for dense_matrix_multiply: loads A and B one element per transaction,
// requests products and checks each element of C against a built-in predictor.
// Depends on dmm_pkg (hdl/dmm_pkg.sv) and the dense_matrix_multiply RTL.
module tb;
  import dmm_pkg::*;

  localparam int MAX_DIM       = 8;
  localparam int STORE_N       = MAX_DIM * MAX_DIM;
  localparam int DIR_N         = 22;
  localparam int RANDOM_ITEMS  = 500;
  localparam int SETTLE_CYCLES = 2 * (MAX_DIM + 4);
  localparam int HOLD_CYCLES   = 800;
  localparam int QUIET_LIMIT   = 5000;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [PROD_W-1:0] product;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic              last;
  } elem_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [POS_W-1:0]  pos;
    logic [VAL_W-1:0]  val;
    logic              typed;
    logic [PROD_W-1:0] product;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // position[5:0], value[21:6], zero pad
  logic [1:0]  s_tuser = '0;   // operation[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;        // product[34:0], out_row[37:35], out_col[40:38], zero pad
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  dense_matrix_multiply #(.MAX_DIM(MAX_DIM)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state: shape registers and both operand stores.
  logic [DIM_W-1:0]        dim_rows = 4'd8;
  logic [DIM_W-1:0]        dim_inner = 4'd8;
  logic [DIM_W-1:0]        dim_cols = 4'd8;
  logic signed [VAL_W-1:0] mat_a [STORE_N];
  logic signed [VAL_W-1:0] mat_b [STORE_N];
  elem_t                   product_q [$];

  // Stimulus side: shape in use and which entries hold a value.
  int unsigned gm = 8, gn = 8, gp = 8;
  bit          gen_wr_a [STORE_N];
  bit          gen_wr_b [STORE_N];
  bit          extreme_vals = 1'b0;
  int          tx_idle_pct = 0;
  int          rx_stall_pct = 0;
  bit          hold_req = 1'b0;
  int          hold_left = 0;
  int          items_sent = 0;
  int          items_accepted = 0;
  int          fail_count = 0;
  int          quiet_cycles = 0;
  logic        item_typed = 1'b0;
  logic [PROD_W-1:0] item_typed_product = '0;

  dir_row_t dir_tab [DIR_N];

  function automatic int unsigned eff_dim(logic [DIM_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > MAX_DIM) return MAX_DIM;
    return 32'(raw);
  endfunction

  task automatic matmul_predict(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                logic [VAL_W-1:0] val);
    int unsigned m, n, p;
    longint acc;
    elem_t e;
    m = eff_dim(dim_rows);
    n = eff_dim(dim_inner);
    p = eff_dim(dim_cols);
    case (op)
      OP_LOAD_A: if (pos < m * n) mat_a[pos] = val;
      OP_LOAD_B: if (pos < n * p) mat_b[pos] = val;
      OP_COMPUTE: begin
        for (int i = 0; i < m; i++) begin
          for (int j = 0; j < p; j++) begin
            acc = 0;
            for (int k = 0; k < n; k++)
              acc += longint'(mat_a[i * n + k]) * longint'(mat_b[k * p + j]);
            e.product = acc[PROD_W-1:0];
            e.row = IDX_W'(i);
            e.col = IDX_W'(j);
            e.last = (i == m - 1) && (j == p - 1);
            product_q.push_back(e);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic note_mismatch(string field, logic [63:0] want, logic [63:0] got);
    fail_count++;
    $error("%s mismatch: expected %0h, got %0h", field, want, got);
  endtask

  // Input side: every accepted transaction goes through the predictor.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      matmul_predict(s_tuser, s_tdata[POS_W-1:0], s_tdata[POS_W+VAL_W-1:POS_W]);
      if (item_typed) begin
        // Directed compute on a 1x1x1 shape: one element, value known by hand.
        void'(product_q.pop_back());
        product_q.push_back('{item_typed_product, '0, '0, 1'b1});
      end
      items_accepted++;
    end
  end

  always @(posedge clk) begin
    if (!rst && psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_ROWS_A:    dim_rows = pwdata[DIM_W-1:0];
        REG_INNER_DIM: dim_inner = pwdata[DIM_W-1:0];
        REG_COLS_B:    dim_cols = pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always @(posedge clk) begin
    elem_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (product_q.size() == 0) begin
        fail_count++;
        $error("unexpected result: product %0h row %0d col %0d last %0b",
               m_tdata[PROD_W-1:0], m_tdata[PROD_W+IDX_W-1:PROD_W],
               m_tdata[PROD_W+2*IDX_W-1:PROD_W+IDX_W], m_tlast);
      end else begin
        want = product_q.pop_front();
        if (m_tdata[PROD_W-1:0] !== want.product)
          note_mismatch("product", 64'(want.product), 64'(m_tdata[PROD_W-1:0]));
        if (m_tdata[PROD_W+IDX_W-1:PROD_W] !== want.row)
          note_mismatch("out_row", 64'(want.row), 64'(m_tdata[PROD_W+IDX_W-1:PROD_W]));
        if (m_tdata[PROD_W+2*IDX_W-1:PROD_W+IDX_W] !== want.col)
          note_mismatch("out_col", 64'(want.col),
                        64'(m_tdata[PROD_W+2*IDX_W-1:PROD_W+IDX_W]));
        if (m_tlast !== want.last)
          note_mismatch("last", 64'(want.last), 64'(m_tlast));
      end
    end
  end

  // Receiver: random stalls, or one long hold-off when requested.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Back-to-back transfers keep psel high; the caller lowers it afterwards.
  task automatic apb_xfer(input logic wr, input logic [1:0] idx, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    psel <= 1'b1;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    penable <= 1'b0;
  endtask

  task automatic check_reg(logic [1:0] idx, logic [DIM_W-1:0] want);
    logic [31:0] rd;
    apb_xfer(1'b0, idx, $urandom(), rd);
    if (rd !== 32'(want))
      note_mismatch($sformatf("register %0d readback", idx), 64'(want), 64'(rd));
  endtask

  task automatic write_reg(logic [1:0] idx, logic [DIM_W-1:0] raw);
    logic [31:0] wd;
    logic [31:0] rd;
    wd = $urandom();
    wd[DIM_W-1:0] = raw;
    apb_xfer(1'b1, idx, wd, rd);
  endtask

  task automatic set_shape(logic [DIM_W-1:0] r_rows, logic [DIM_W-1:0] r_inner,
                           logic [DIM_W-1:0] r_cols);
    write_reg(REG_ROWS_A, r_rows);
    write_reg(REG_INNER_DIM, r_inner);
    write_reg(REG_COLS_B, r_cols);
    check_reg(REG_ROWS_A, r_rows);
    check_reg(REG_INNER_DIM, r_inner);
    check_reg(REG_COLS_B, r_cols);
    psel <= 1'b0;
    gm = eff_dim(r_rows);
    gn = eff_dim(r_inner);
    gp = eff_dim(r_cols);
  endtask

  task automatic send_item(logic [OP_W-1:0] op, logic [POS_W-1:0] pos, logic [VAL_W-1:0] val,
                           logic typed = 1'b0, logic [PROD_W-1:0] typed_prod = '0);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat (($urandom_range(9) == 0) ? $urandom_range(4, 30) : $urandom_range(1, 3))
        @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {2'b00, val, pos};
    item_typed <= typed;
    item_typed_product <= typed_prod;
    if (op == OP_LOAD_A && pos < gm * gn) gen_wr_a[pos] = 1'b1;
    if (op == OP_LOAD_B && pos < gn * gp) gen_wr_b[pos] = 1'b1;
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  // Stop offering and wait until every transaction is through and all of C is out.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    item_typed <= 1'b0;
    while (items_accepted != items_sent || product_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [VAL_W-1:0] rand_value();
    if (extreme_vals) return $urandom_range(1) ? 16'h8000 : 16'h7fff;
    case ($urandom_range(7))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return VAL_W'($urandom());
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] rand_dim();
    case ($urandom_range(9))
      0: return '0;
      1: return DIM_W'($urandom_range(MAX_DIM + 1, 15));
      2: return DIM_W'(MAX_DIM);
      default: return DIM_W'($urandom_range(1, 4));
    endcase
  endfunction

  // Random entry of A (or B) inside the current shape that holds no value yet, or -1.
  function automatic int find_missing(bit of_b);
    int q [$];
    int lim;
    lim = of_b ? gn * gp : gm * gn;
    for (int e = 0; e < lim; e++)
      if (!(of_b ? gen_wr_b[e] : gen_wr_a[e])) q.push_back(e);
    if (q.size() == 0) return -1;
    return q[$urandom_range(q.size() - 1)];
  endfunction

  task automatic fill_and_compute();
    int e;
    e = find_missing(1'b0);
    while (e >= 0) begin
      send_item(OP_LOAD_A, POS_W'(e), rand_value());
      e = find_missing(1'b0);
    end
    e = find_missing(1'b1);
    while (e >= 0) begin
      send_item(OP_LOAD_B, POS_W'(e), rand_value());
      e = find_missing(1'b1);
    end
    send_item(OP_COMPUTE, POS_W'($urandom()), VAL_W'($urandom()));
  endtask

  task automatic run_phase(int mode, logic [DIM_W-1:0] r_rows, logic [DIM_W-1:0] r_inner,
                           logic [DIM_W-1:0] r_cols, bit extreme, bit hold);
    int n_items, r, miss_a, miss_b, lim;
    logic [OP_W-1:0] op;
    tx_idle_pct = (mode == 1) ? 71 : (mode == 3) ? 33 : 0;
    rx_stall_pct = (mode == 2) ? 71 : (mode == 3) ? 33 : 0;
    set_shape(r_rows, r_inner, r_cols);
    extreme_vals = extreme;
    n_items = 20 + (gm * gn + gn * gp) / 2;
    if (hold) begin
      // The receiver stops while a full product is pending, so the input backs up.
      hold_req = 1'b1;
      fill_and_compute();
    end
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(99);
      miss_a = find_missing(1'b0);
      miss_b = find_missing(1'b1);
      op = $urandom_range(1) ? OP_LOAD_B : OP_LOAD_A;
      lim = (op == OP_LOAD_A) ? gm * gn : gn * gp;
      if (r < 30 && (miss_a >= 0 || miss_b >= 0)) begin
        if (miss_a >= 0 && (miss_b < 0 || $urandom_range(1)))
          send_item(OP_LOAD_A, POS_W'(miss_a), rand_value());
        else
          send_item(OP_LOAD_B, POS_W'(miss_b), rand_value());
      end else if (r < 45 && miss_a < 0 && miss_b < 0) begin
        send_item(OP_COMPUTE, POS_W'($urandom()), VAL_W'($urandom()));
      end else if (r < 85) begin
        send_item(op, POS_W'($urandom_range(lim - 1)), rand_value());
      end else if (r < 93) begin
        // Load beyond the shape if it leaves room, else anywhere; out-of-shape loads must leave the stores untouched.
        if (lim < STORE_N)
          send_item(op, POS_W'($urandom_range(STORE_N - 1, lim)), rand_value());
        else
          send_item(op, POS_W'($urandom()), rand_value());
      end else begin
        send_item(OP_UNUSED, POS_W'($urandom()), VAL_W'($urandom()));
      end
    end
    fill_and_compute();
    wait_drained();
  endtask

  initial begin
    // Shape 1x1x1: each compute returns one element, row 0, column 0, last set.
    dir_tab = '{
      '{OP_LOAD_A,  6'd0,  16'h7fff, 1'b0, 35'h0},
      '{OP_LOAD_B,  6'd0,  16'h7fff, 1'b0, 35'h0},
      '{OP_COMPUTE, 6'd0,  16'h0000, 1'b1, 35'h0_3fff_0001},
      '{OP_LOAD_A,  6'd0,  16'h8000, 1'b0, 35'h0},
      '{OP_LOAD_B,  6'd0,  16'h8000, 1'b0, 35'h0},
      '{OP_COMPUTE, 6'd0,  16'h0000, 1'b1, 35'h0_4000_0000},
      '{OP_LOAD_B,  6'd0,  16'h7fff, 1'b0, 35'h0},
      '{OP_COMPUTE, 6'd63, 16'hffff, 1'b1, 35'h7_c000_8000},
      '{OP_LOAD_A,  6'd1,  16'h1234, 1'b0, 35'h0},
      '{OP_LOAD_B,  6'd63, 16'h5555, 1'b0, 35'h0},
      '{OP_LOAD_A,  6'd63, 16'haaaa, 1'b0, 35'h0},
      '{OP_UNUSED,  6'd0,  16'hffff, 1'b0, 35'h0},
      '{OP_UNUSED,  6'd63, 16'h0000, 1'b0, 35'h0},
      '{OP_COMPUTE, 6'd0,  16'h0000, 1'b1, 35'h7_c000_8000},
      '{OP_LOAD_A,  6'd0,  16'hffff, 1'b0, 35'h0},
      '{OP_COMPUTE, 6'd0,  16'h0000, 1'b1, 35'h7_ffff_8001},
      '{OP_LOAD_B,  6'd0,  16'hffff, 1'b0, 35'h0},
      '{OP_COMPUTE, 6'd0,  16'h0000, 1'b1, 35'h0_0000_0001},
      '{OP_LOAD_A,  6'd0,  16'h0000, 1'b0, 35'h0},
      '{OP_COMPUTE, 6'd0,  16'h0000, 1'b1, 35'h0},
      '{OP_LOAD_B,  6'd0,  16'h0000, 1'b0, 35'h0},
      '{OP_COMPUTE, 6'd0,  16'h0000, 1'b1, 35'h0}
    };
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    check_reg(REG_ROWS_A, 4'd8);
    check_reg(REG_INNER_DIM, 4'd8);
    check_reg(REG_COLS_B, 4'd8);
    set_shape(4'd1, 4'd1, 4'd1);
    for (int i = 0; i < DIR_N; i++)
      send_item(dir_tab[i].op, dir_tab[i].pos, dir_tab[i].val, dir_tab[i].typed,
                dir_tab[i].product);
    wait_drained();

    run_phase(0, 4'd8, 4'd8, 4'd8, 1'b1, 1'b0);
    run_phase(1, 4'd0, 4'd15, 4'd0, 1'b0, 1'b0);
    run_phase(0, 4'd15, 4'd0, 4'd15, 1'b0, 1'b1);
    run_phase(2, 4'd2, 4'd3, 4'd4, 1'b0, 1'b0);
    for (int ph = 4; items_sent < DIR_N + RANDOM_ITEMS; ph++)
      run_phase(ph % 4, rand_dim(), rand_dim(), rand_dim(), 1'b0, 1'b0);

    if (product_q.size() != 0) begin
      fail_count++;
      $error("%0d expected elements never arrived", product_q.size());
    end
    if (fail_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
